// ===== src/cis_pkg.sv =====
// Shared types, codes and saturation helpers of the two-body contact solver.
package cis_pkg;

  typedef logic signed [31:0] fx_t;

  localparam logic signed [63:0] FX_MAX = 64'sd2147483647;
  localparam logic signed [63:0] FX_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_SOLVE   = 3'd1,
    CMD_CORRECT = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_APPLIED     = 2'd0,
    STAT_SEPARATING  = 2'd1,
    STAT_ZERO_MASS   = 2'd2,
    STAT_NO_FRICTION = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_NORMAL_X    = 3'd0,
    REG_NORMAL_Y    = 3'd1,
    REG_RESTITUTION = 3'd2,
    REG_FRICTION    = 3'd3,
    REG_DEPTH       = 3'd4,
    REG_BIAS        = 3'd5,
    REG_SLOP        = 3'd6
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ARM,
    ST_RV0, ST_RV1, ST_RV2, ST_RV3, ST_RV4, ST_RV5,
    ST_VN1, ST_VN2, ST_VN3,
    ST_EM1, ST_EM2, ST_EM3, ST_EM4, ST_EM5, ST_EM6, ST_EM7, ST_EM8, ST_EM9,
    ST_DEC, ST_J1, ST_J2, ST_JW, ST_J4,
    ST_AP1, ST_AP2, ST_AP3, ST_AP4, ST_AP5, ST_AP6, ST_AP7, ST_AP8,
    ST_AP9, ST_AP10, ST_AP11, ST_AP12, ST_AP13, ST_AP14, ST_AP15,
    ST_T1, ST_T2, ST_T3, ST_T4,
    ST_F1, ST_F2, ST_FW, ST_F4, ST_F5,
    ST_C1, ST_C2, ST_C3, ST_CW, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8, ST_C9, ST_C10,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic               body_select;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_spin;
    logic [30:0]        load_inv_mass;
    logic [30:0]        load_inv_inertia;
    logic               contact_slot;
  } cis_in_t;

  typedef struct packed {
    logic               which_body;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_spin;
    logic [30:0]        out_acc_normal;
    logic signed [31:0] out_acc_tangent;
    logic [1:0]         solve_status;
    logic               last_item;
  } cis_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cis_cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic [30:0]        den;
  } div_req_t;

  typedef struct packed {
    logic done;
    fx_t  quot;
  } div_rsp_t;

  function automatic fx_t sat64(input logic signed [63:0] v);
    if (v > FX_MAX) return fx_t'(FX_MAX);
    if (v < FX_MIN) return fx_t'(FX_MIN);
    return fx_t'(v);
  endfunction

  function automatic fx_t add_s(input fx_t a, input fx_t b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic fx_t sub_s(input fx_t a, input fx_t b);
    return sat64(64'(a) - 64'(b));
  endfunction

endpackage

// ===== src/cis_chan_if.sv =====
// Valid/ready channel carrying one payload struct.
interface cis_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/cis_div.sv =====
// Bit-serial fixed-point divider with truncation toward zero and saturation.
module cis_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cis_pkg::div_req_t   req,
  output cis_pkg::div_rsp_t   rsp
);
  import cis_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r, quo_r;
  logic [31:0]   rem_r;
  logic [30:0]   den_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   mag;
  logic [32:0]   trial;
  logic          fits;
  fx_t           quot;

  assign mag   = req.num[32] ? 32'(-req.num) : 32'(req.num);
  assign trial = {rem_r, dvd_r[DW-1]};
  assign fits  = trial >= {2'b00, den_r};

  always_comb begin
    if (!neg_r) begin
      quot = (|quo_r[DW-1:31]) ? fx_t'(FX_MAX) : fx_t'(quo_r[31:0]);
    end else if ((|quo_r[DW-1:32]) || (quo_r[31] && (|quo_r[30:0]))) begin
      quot = fx_t'(FX_MIN);
    end else begin
      quot = fx_t'(-quo_r[31:0]);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= {mag, {FRAC_BITS{1'b0}}};
      quo_r <= '0;
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.num[32];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? 32'(trial - {2'b00, den_r}) : trial[31:0];
    end
  end

endmodule

// ===== src/contact_impulse_solver_2d_top.sv =====
// Two-body contact impulse solver: sequencer, state registers and shared multiplier.
//
//  channel  dir  handshake        payload
//  in_if    in   valid/ready      command, body fields, contact point, slot
//  out_if   out  valid/ready      body state, slot accumulators, status
//  cfg_if   in   valid/ready      register index, write data
//
//  Load and clear complete in the idle state; read goes from the idle state to two output transfers.
//  A full solve runs on one shared 32x32 multiplier stepped once a cycle and two bit-serial
//  divides; correct uses the same multiplier and one divide. While out_if.ready stays low,
//  the block holds its result in the output state.
//  The input is not ready until both results transfer.
//  Reset (rst_n low, synchronous) zeroes bodies and accumulators.
module contact_impulse_solver_2d_top #(
  parameter int MAX_CONTACTS = 2,
  parameter int FRAC_BITS    = 16
) (
  input logic       clk,
  input logic       rst_n,
  cis_chan_if.sink   in_if,
  cis_chan_if.source out_if,
  cis_chan_if.sink   cfg_if
);
  import cis_pkg::*;

  localparam int    SLOT_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam longint ONE   = longint'(1) << FRAC_BITS;

  state_t state_r, state_nxt;
  logic   which_r, which_nxt, pass_r, pass_nxt;
  logic [1:0] status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  fx_t pos_x_r [2], pos_x_nxt [2];
  fx_t pos_y_r [2], pos_y_nxt [2];
  fx_t vel_x_r [2], vel_x_nxt [2];
  fx_t vel_y_r [2], vel_y_nxt [2];
  fx_t spin_r  [2], spin_nxt  [2];
  logic [30:0] im_r [2], im_nxt [2];
  logic [30:0] ii_r [2], ii_nxt [2];
  logic [30:0] acc_n_r [MAX_CONTACTS], acc_n_nxt [MAX_CONTACTS];
  fx_t         acc_t_r [MAX_CONTACTS], acc_t_nxt [MAX_CONTACTS];

  logic signed [17:0] nx_r, ny_r;
  logic [16:0] rest_r, bias_r;
  logic [20:0] mu_r;
  logic [30:0] depth_r, slop_r;

  fx_t px_r, px_nxt, py_r, py_nxt;
  fx_t rax_r, rax_nxt, ray_r, ray_nxt, rbx_r, rbx_nxt, rby_r, rby_nxt;
  fx_t vax_r, vax_nxt, vay_r, vay_nxt, vbx_r, vbx_nxt, vby_r, vby_nxt;
  fx_t vx_r, vx_nxt, vy_r, vy_nxt, vn_r, vn_nxt;
  fx_t dx_r, dx_nxt, dy_r, dy_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  fx_t t0_r, t0_nxt, t1_r, t1_nxt, msum_r, msum_nxt;
  fx_t lam_r, lam_nxt, ix_r, ix_nxt, iy_r, iy_nxt, old_r, old_nxt, mx_r, mx_nxt;
  fx_t m_r;

  fx_t ma, mb, mul_q;
  logic signed [63:0] prod, prod_sh;
  div_req_t div_req;
  div_rsp_t div_rsp;

  fx_t nx_s, ny_s, acc_n_s, acc_t_s, im0_s, im1_s, ii0_s, ii1_s;
  logic signed [63:0] em_sum;
  fx_t tmp;
  logic [31:0] ms_sum;
  logic signed [31:0] depth_diff;

  assign nx_s    = fx_t'(nx_r);
  assign ny_s    = fx_t'(ny_r);
  assign acc_n_s = fx_t'({1'b0, acc_n_r[slot_r]});
  assign acc_t_s = acc_t_r[slot_r];
  assign im0_s   = fx_t'({1'b0, im_r[0]});
  assign im1_s   = fx_t'({1'b0, im_r[1]});
  assign ii0_s   = fx_t'({1'b0, ii_r[0]});
  assign ii1_s   = fx_t'({1'b0, ii_r[1]});

  assign prod    = ma * mb;
  assign prod_sh = prod >>> FRAC_BITS;
  assign mul_q   = sat64(prod_sh);

  cis_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid                = (state_r == ST_OUT);
  assign out_if.data.which_body      = which_r;
  assign out_if.data.out_pos_x       = pos_x_r[which_r];
  assign out_if.data.out_pos_y       = pos_y_r[which_r];
  assign out_if.data.out_vel_x       = vel_x_r[which_r];
  assign out_if.data.out_vel_y       = vel_y_r[which_r];
  assign out_if.data.out_spin        = spin_r[which_r];
  assign out_if.data.out_acc_normal  = acc_n_r[slot_r];
  assign out_if.data.out_acc_tangent = acc_t_r[slot_r];
  assign out_if.data.solve_status    = status_r;
  assign out_if.data.last_item       = which_r;

  assign em_sum     = 64'(im0_s) + 64'(im1_s) + 64'(t0_r) + 64'(m_r);
  assign ms_sum     = {1'b0, im_r[0]} + {1'b0, im_r[1]};
  assign depth_diff = $signed({1'b0, depth_r}) - $signed({1'b0, slop_r});

  always_comb begin
    state_nxt  = state_r;
    which_nxt  = which_r;
    pass_nxt   = pass_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    vel_x_nxt  = vel_x_r;
    vel_y_nxt  = vel_y_r;
    spin_nxt   = spin_r;
    im_nxt     = im_r;
    ii_nxt     = ii_r;
    acc_n_nxt  = acc_n_r;
    acc_t_nxt  = acc_t_r;
    px_nxt = px_r;   py_nxt = py_r;
    rax_nxt = rax_r; ray_nxt = ray_r; rbx_nxt = rbx_r; rby_nxt = rby_r;
    vax_nxt = vax_r; vay_nxt = vay_r; vbx_nxt = vbx_r; vby_nxt = vby_r;
    vx_nxt = vx_r;   vy_nxt = vy_r;   vn_nxt = vn_r;
    dx_nxt = dx_r;   dy_nxt = dy_r;   ca_nxt = ca_r;   cb_nxt = cb_r;
    t0_nxt = t0_r;   t1_nxt = t1_r;   msum_nxt = msum_r;
    lam_nxt = lam_r; ix_nxt = ix_r;   iy_nxt = iy_r;   old_nxt = old_r;
    mx_nxt = mx_r;
    ma = '0;
    mb = '0;
    tmp = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = msum_r[30:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          px_nxt     = in_if.data.x_coord;
          py_nxt     = in_if.data.y_coord;
          slot_nxt   = (MAX_CONTACTS > 1) ? SLOT_W'(in_if.data.contact_slot) : '0;
          status_nxt = STAT_APPLIED;
          which_nxt  = 1'b0;
          pass_nxt   = 1'b0;
          case (in_if.data.command)
            CMD_LOAD: begin
              pos_x_nxt[in_if.data.body_select] = in_if.data.x_coord;
              pos_y_nxt[in_if.data.body_select] = in_if.data.y_coord;
              vel_x_nxt[in_if.data.body_select] = in_if.data.load_vel_x;
              vel_y_nxt[in_if.data.body_select] = in_if.data.load_vel_y;
              spin_nxt[in_if.data.body_select]  = in_if.data.load_spin;
              im_nxt[in_if.data.body_select]    = in_if.data.load_inv_mass;
              ii_nxt[in_if.data.body_select]    = in_if.data.load_inv_inertia;
            end
            CMD_CLEAR: begin
              for (int k = 0; k < MAX_CONTACTS; k++) begin
                acc_n_nxt[k] = '0;
                acc_t_nxt[k] = '0;
              end
            end
            CMD_SOLVE:   state_nxt = ST_ARM;
            CMD_CORRECT: state_nxt = ST_C1;
            CMD_READ:    state_nxt = ST_OUT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ARM: begin
        rax_nxt = sub_s(px_r, pos_x_r[0]);
        ray_nxt = sub_s(py_r, pos_y_r[0]);
        rbx_nxt = sub_s(px_r, pos_x_r[1]);
        rby_nxt = sub_s(py_r, pos_y_r[1]);
        state_nxt = ST_RV0;
      end
      ST_RV0: begin ma = spin_r[0]; mb = ray_r; state_nxt = ST_RV1; end
      ST_RV1: begin
        vax_nxt = sub_s(vel_x_r[0], m_r); ma = spin_r[0]; mb = rax_r; state_nxt = ST_RV2;
      end
      ST_RV2: begin
        vay_nxt = add_s(vel_y_r[0], m_r); ma = spin_r[1]; mb = rby_r; state_nxt = ST_RV3;
      end
      ST_RV3: begin
        vbx_nxt = sub_s(vel_x_r[1], m_r); ma = spin_r[1]; mb = rbx_r; state_nxt = ST_RV4;
      end
      ST_RV4: begin vby_nxt = add_s(vel_y_r[1], m_r); state_nxt = ST_RV5; end
      ST_RV5: begin
        vx_nxt = sub_s(vbx_r, vax_r);
        vy_nxt = sub_s(vby_r, vay_r);
        state_nxt = pass_r ? ST_T1 : ST_VN1;
      end
      ST_VN1: begin ma = vx_r; mb = nx_s; state_nxt = ST_VN2; end
      ST_VN2: begin t0_nxt = m_r; ma = vy_r; mb = ny_s; state_nxt = ST_VN3; end
      ST_VN3: begin
        vn_nxt = add_s(t0_r, m_r);
        dx_nxt = nx_s;
        dy_nxt = ny_s;
        state_nxt = ST_EM1;
      end
      ST_EM1: begin ma = rax_r; mb = dy_r; state_nxt = ST_EM2; end
      ST_EM2: begin t0_nxt = m_r; ma = ray_r; mb = dx_r; state_nxt = ST_EM3; end
      ST_EM3: begin ca_nxt = sub_s(t0_r, m_r); ma = rbx_r; mb = dy_r; state_nxt = ST_EM4; end
      ST_EM4: begin t0_nxt = m_r; ma = rby_r; mb = dx_r; state_nxt = ST_EM5; end
      ST_EM5: begin cb_nxt = sub_s(t0_r, m_r); ma = ca_r; mb = ca_r; state_nxt = ST_EM6; end
      ST_EM6: begin ma = m_r; mb = ii0_s; state_nxt = ST_EM7; end
      ST_EM7: begin t0_nxt = m_r; ma = cb_r; mb = cb_r; state_nxt = ST_EM8; end
      ST_EM8: begin ma = m_r; mb = ii1_s; state_nxt = ST_EM9; end
      ST_EM9: begin msum_nxt = sat64(em_sum); state_nxt = ST_DEC; end
      ST_DEC: begin
        if (!pass_r) begin
          if (vn_r > 0) begin
            status_nxt = STAT_SEPARATING;
            state_nxt  = ST_OUT;
          end else if (msum_r <= 0) begin
            status_nxt = STAT_ZERO_MASS;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_J1;
          end
        end else if (msum_r <= 0) begin
          status_nxt = STAT_NO_FRICTION;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_F1;
        end
      end
      ST_J1: begin
        ma = fx_t'(ONE + longint'(rest_r));
        mb = vn_r;
        state_nxt = ST_J2;
      end
      ST_J2: begin
        div_req.start = 1'b1;
        div_req.num   = -{m_r[31], m_r};
        state_nxt     = ST_JW;
      end
      ST_JW: begin
        if (div_rsp.done) begin
          tmp = add_s(acc_n_s, div_rsp.quot);
          if (tmp < 0) begin
            tmp = '0;
          end
          acc_n_nxt[slot_r] = tmp[30:0];
          old_nxt   = acc_n_s;
          state_nxt = ST_J4;
        end
      end
      ST_J4: begin lam_nxt = sub_s(acc_n_s, old_r); state_nxt = ST_AP1; end
      ST_AP1: begin ma = dx_r; mb = lam_r; state_nxt = ST_AP2; end
      ST_AP2: begin ix_nxt = m_r; ma = dy_r; mb = lam_r; state_nxt = ST_AP3; end
      ST_AP3: begin iy_nxt = m_r; ma = ix_r; mb = im0_s; state_nxt = ST_AP4; end
      ST_AP4: begin
        vel_x_nxt[0] = sub_s(vel_x_r[0], m_r); ma = iy_r; mb = im0_s; state_nxt = ST_AP5;
      end
      ST_AP5: begin
        vel_y_nxt[0] = sub_s(vel_y_r[0], m_r); ma = rax_r; mb = iy_r; state_nxt = ST_AP6;
      end
      ST_AP6: begin t0_nxt = m_r; ma = ray_r; mb = ix_r; state_nxt = ST_AP7; end
      ST_AP7: begin t0_nxt = sub_s(t0_r, m_r); state_nxt = ST_AP8; end
      ST_AP8: begin ma = t0_r; mb = ii0_s; state_nxt = ST_AP9; end
      ST_AP9: begin
        spin_nxt[0] = sub_s(spin_r[0], m_r); ma = ix_r; mb = im1_s; state_nxt = ST_AP10;
      end
      ST_AP10: begin
        vel_x_nxt[1] = add_s(vel_x_r[1], m_r); ma = iy_r; mb = im1_s; state_nxt = ST_AP11;
      end
      ST_AP11: begin
        vel_y_nxt[1] = add_s(vel_y_r[1], m_r); ma = rbx_r; mb = iy_r; state_nxt = ST_AP12;
      end
      ST_AP12: begin t0_nxt = m_r; ma = rby_r; mb = ix_r; state_nxt = ST_AP13; end
      ST_AP13: begin t0_nxt = sub_s(t0_r, m_r); state_nxt = ST_AP14; end
      ST_AP14: begin ma = t0_r; mb = ii1_s; state_nxt = ST_AP15; end
      ST_AP15: begin
        spin_nxt[1] = add_s(spin_r[1], m_r);
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_RV0;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_T1: begin ma = vx_r; mb = -ny_s; state_nxt = ST_T2; end
      ST_T2: begin t0_nxt = m_r; ma = vy_r; mb = nx_s; state_nxt = ST_T3; end
      ST_T3: begin vn_nxt = add_s(t0_r, m_r); state_nxt = ST_T4; end
      ST_T4: begin
        if (vn_r < 0) begin
          dx_nxt = ny_s;
          dy_nxt = -nx_s;
        end else begin
          dx_nxt = -ny_s;
          dy_nxt = nx_s;
        end
        state_nxt = ST_EM1;
      end
      ST_F1: begin
        ma = fx_t'({11'b0, mu_r});
        mb = acc_n_s;
        div_req.start = 1'b1;
        div_req.num   = (vn_r < 0) ? {vn_r[31], vn_r} : -{vn_r[31], vn_r};
        state_nxt     = ST_F2;
      end
      ST_F2: begin mx_nxt = m_r; state_nxt = ST_FW; end
      ST_FW: begin
        if (div_rsp.done) begin
          t1_nxt    = add_s(acc_t_s, div_rsp.quot);
          old_nxt   = acc_t_s;
          state_nxt = ST_F4;
        end
      end
      ST_F4: begin
        tmp = (t1_r > mx_r) ? mx_r : t1_r;
        if (tmp < -mx_r) begin
          tmp = -mx_r;
        end
        acc_t_nxt[slot_r] = tmp;
        state_nxt = ST_F5;
      end
      ST_F5: begin lam_nxt = sub_s(acc_t_s, old_r); state_nxt = ST_AP1; end
      ST_C1: begin
        t0_nxt   = (depth_diff < 0) ? '0 : depth_diff;
        msum_nxt = ms_sum[31] ? fx_t'(FX_MAX) : fx_t'(ms_sum);
        if (ms_sum == '0) begin
          status_nxt = STAT_ZERO_MASS;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_C2;
        end
      end
      ST_C2: begin ma = t0_r; mb = fx_t'({15'b0, bias_r}); state_nxt = ST_C3; end
      ST_C3: begin
        div_req.start = 1'b1;
        div_req.num   = {m_r[31], m_r};
        state_nxt     = ST_CW;
      end
      ST_CW: begin
        if (div_rsp.done) begin
          lam_nxt   = div_rsp.quot;
          state_nxt = ST_C4;
        end
      end
      ST_C4: begin ma = nx_s; mb = lam_r; state_nxt = ST_C5; end
      ST_C5: begin t0_nxt = m_r; ma = ny_s; mb = lam_r; state_nxt = ST_C6; end
      ST_C6: begin t1_nxt = m_r; ma = t0_r; mb = im0_s; state_nxt = ST_C7; end
      ST_C7: begin
        pos_x_nxt[0] = sub_s(pos_x_r[0], m_r); ma = t1_r; mb = im0_s; state_nxt = ST_C8;
      end
      ST_C8: begin
        pos_y_nxt[0] = sub_s(pos_y_r[0], m_r); ma = t0_r; mb = im1_s; state_nxt = ST_C9;
      end
      ST_C9: begin
        pos_x_nxt[1] = add_s(pos_x_r[1], m_r); ma = t1_r; mb = im1_s; state_nxt = ST_C10;
      end
      ST_C10: begin pos_y_nxt[1] = add_s(pos_y_r[1], m_r); state_nxt = ST_OUT; end
      ST_OUT: begin
        if (out_if.ready) begin
          if (!which_r) begin
            which_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      which_r  <= 1'b0;
      pass_r   <= 1'b0;
      status_r <= STAT_APPLIED;
      slot_r   <= '0;
      for (int k = 0; k < 2; k++) begin
        pos_x_r[k] <= '0;
        pos_y_r[k] <= '0;
        vel_x_r[k] <= '0;
        vel_y_r[k] <= '0;
        spin_r[k]  <= '0;
        im_r[k]    <= '0;
        ii_r[k]    <= '0;
      end
      for (int k = 0; k < MAX_CONTACTS; k++) begin
        acc_n_r[k] <= '0;
        acc_t_r[k] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      which_r  <= which_nxt;
      pass_r   <= pass_nxt;
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      vel_x_r  <= vel_x_nxt;
      vel_y_r  <= vel_y_nxt;
      spin_r   <= spin_nxt;
      im_r     <= im_nxt;
      ii_r     <= ii_nxt;
      acc_n_r  <= acc_n_nxt;
      acc_t_r  <= acc_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r    <= '0;
      ny_r    <= 18'(ONE);
      rest_r  <= '0;
      mu_r    <= '0;
      depth_r <= '0;
      bias_r  <= 17'(ONE / 5);
      slop_r  <= 31'(ONE / 100);
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        REG_NORMAL_X:    nx_r    <= cfg_if.data.value[17:0];
        REG_NORMAL_Y:    ny_r    <= cfg_if.data.value[17:0];
        REG_RESTITUTION: rest_r  <= cfg_if.data.value[16:0];
        REG_FRICTION:    mu_r    <= cfg_if.data.value[20:0];
        REG_DEPTH:       depth_r <= cfg_if.data.value[30:0];
        REG_BIAS:        bias_r  <= cfg_if.data.value[16:0];
        REG_SLOP:        slop_r  <= cfg_if.data.value[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= mul_q;
    px_r   <= px_nxt;   py_r   <= py_nxt;
    rax_r  <= rax_nxt;  ray_r  <= ray_nxt;  rbx_r <= rbx_nxt; rby_r <= rby_nxt;
    vax_r  <= vax_nxt;  vay_r  <= vay_nxt;  vbx_r <= vbx_nxt; vby_r <= vby_nxt;
    vx_r   <= vx_nxt;   vy_r   <= vy_nxt;   vn_r  <= vn_nxt;
    dx_r   <= dx_nxt;   dy_r   <= dy_nxt;   ca_r  <= ca_nxt;  cb_r  <= cb_nxt;
    t0_r   <= t0_nxt;   t1_r   <= t1_nxt;   msum_r <= msum_nxt;
    lam_r  <= lam_nxt;  ix_r   <= ix_nxt;   iy_r  <= iy_nxt;  old_r <= old_nxt;
    mx_r   <= mx_nxt;
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !out_if.valid)
    else $error("input ready while a result is pending");

  a_pair_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && out_if.data.last_item |=> !out_if.valid)
    else $error("result valid after final transfer");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_JW || state_r == ST_FW || state_r == ST_CW))
    else $error("divide finished outside a wait state");

endmodule

// ===== test/contact_impulse_solver_2d_top_tb.sv =====
// Self-checking testbench of the two-body contact impulse solver.
module contact_impulse_solver_2d_top_tb;
  import cis_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  cis_chan_if #(.T(cis_in_t))  in_ch ();
  cis_chan_if #(.T(cis_out_t)) out_ch ();
  cis_chan_if #(.T(cis_cfg_t)) cfg_ch ();

  contact_impulse_solver_2d_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch.sink),
    .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  longint pos_x_m[2], pos_y_m[2], vel_x_m[2], vel_y_m[2], spin_m[2], imass_m[2], iinert_m[2];
  longint accn_m[2], acct_m[2];
  longint nx_r, ny_r, rest_r, mu_r, depth_r, bias_r, slop_r;

  cis_in_t  pending_items[$];
  cis_out_t body_results[$];
  int       error_count;
  int       idle_cycles;
  int       item_count;
  int       result_count;
  bit       quiet_mode;
  bit       hold_off;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat(p >>> 16);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    return sat((n * 65536) / d);
  endfunction

  function automatic longint fcross(longint ax, longint ay, longint bx, longint by);
    return sat(fmul(ax, by) - fmul(ay, bx));
  endfunction

  task automatic contact_vel(input longint rax, ray, rbx, rby, output longint vx, vy);
    longint ax, ay, bx, by;
    ax = sat(vel_x_m[0] - fmul(spin_m[0], ray));
    ay = sat(vel_y_m[0] + fmul(spin_m[0], rax));
    bx = sat(vel_x_m[1] - fmul(spin_m[1], rby));
    by = sat(vel_y_m[1] + fmul(spin_m[1], rbx));
    vx = sat(bx - ax);
    vy = sat(by - ay);
  endtask

  function automatic longint effective_mass(longint rax, ray, rbx, rby, dx, dy);
    longint ca, cb;
    ca = fcross(rax, ray, dx, dy);
    cb = fcross(rbx, rby, dx, dy);
    return sat(imass_m[0] + imass_m[1] + fmul(fmul(ca, ca), iinert_m[0])
               + fmul(fmul(cb, cb), iinert_m[1]));
  endfunction

  task automatic apply_impulse(input longint rax, ray, rbx, rby, dx, dy, lam);
    longint ix, iy, s, rx, ry;
    ix = fmul(dx, lam);
    iy = fmul(dy, lam);
    for (int k = 0; k < 2; k++) begin
      s = (k == 0) ? -1 : 1;
      rx = (k == 0) ? rax : rbx;
      ry = (k == 0) ? ray : rby;
      vel_x_m[k] = sat(vel_x_m[k] + s * fmul(ix, imass_m[k]));
      vel_y_m[k] = sat(vel_y_m[k] + s * fmul(iy, imass_m[k]));
      spin_m[k] = sat(spin_m[k] + s * fmul(fcross(rx, ry, ix, iy), iinert_m[k]));
    end
  endtask

  task automatic predict_bodies(input cis_in_t it);
    longint px, py, rax, ray, rbx, rby, vx, vy, vn, msum, j, old, nw, tx, ty, vt, mt, jt, mx;
    longint dep, ms, c, cx, cy;
    status_t st;
    cis_out_t r;
    int sl;
    st = STAT_APPLIED;
    sl = it.contact_slot;
    px = it.x_coord;
    py = it.y_coord;
    case (it.command)
      CMD_LOAD: begin
        pos_x_m[it.body_select] = it.x_coord;
        pos_y_m[it.body_select] = it.y_coord;
        vel_x_m[it.body_select] = it.load_vel_x;
        vel_y_m[it.body_select] = it.load_vel_y;
        spin_m[it.body_select] = it.load_spin;
        imass_m[it.body_select] = it.load_inv_mass;
        iinert_m[it.body_select] = it.load_inv_inertia;
        return;
      end
      CMD_CLEAR: begin
        accn_m = '{0, 0};
        acct_m = '{0, 0};
        return;
      end
      CMD_SOLVE: begin
        rax = sat(px - pos_x_m[0]);
        ray = sat(py - pos_y_m[0]);
        rbx = sat(px - pos_x_m[1]);
        rby = sat(py - pos_y_m[1]);
        contact_vel(rax, ray, rbx, rby, vx, vy);
        vn = sat(fmul(vx, nx_r) + fmul(vy, ny_r));
        msum = effective_mass(rax, ray, rbx, rby, nx_r, ny_r);
        if (vn > 0) begin
          st = STAT_SEPARATING;
        end else if (msum <= 0) begin
          st = STAT_ZERO_MASS;
        end else begin
          j = fdiv(-fmul(65536 + rest_r, vn), msum);
          old = accn_m[sl];
          nw = sat(old + j);
          if (nw < 0) nw = 0;
          accn_m[sl] = nw;
          apply_impulse(rax, ray, rbx, rby, nx_r, ny_r, sat(nw - old));
          contact_vel(rax, ray, rbx, rby, vx, vy);
          vt = sat(fmul(vx, -ny_r) + fmul(vy, nx_r));
          tx = -ny_r;
          ty = nx_r;
          if (vt < 0) begin
            tx = -tx;
            ty = -ty;
          end
          mt = effective_mass(rax, ray, rbx, rby, tx, ty);
          if (mt <= 0) begin
            st = STAT_NO_FRICTION;
          end else begin
            jt = fdiv(vt < 0 ? vt : -vt, mt);
            mx = fmul(mu_r, nw);
            old = acct_m[sl];
            nw = sat(old + jt);
            if (nw > mx) nw = mx;
            if (nw < -mx) nw = -mx;
            acct_m[sl] = nw;
            apply_impulse(rax, ray, rbx, rby, tx, ty, sat(nw - old));
          end
        end
      end
      CMD_CORRECT: begin
        dep = depth_r - slop_r;
        if (dep < 0) dep = 0;
        ms = sat(imass_m[0] + imass_m[1]);
        if (ms <= 0) begin
          st = STAT_ZERO_MASS;
        end else begin
          c = fdiv(fmul(dep, bias_r), ms);
          cx = fmul(nx_r, c);
          cy = fmul(ny_r, c);
          pos_x_m[0] = sat(pos_x_m[0] - fmul(cx, imass_m[0]));
          pos_y_m[0] = sat(pos_y_m[0] - fmul(cy, imass_m[0]));
          pos_x_m[1] = sat(pos_x_m[1] + fmul(cx, imass_m[1]));
          pos_y_m[1] = sat(pos_y_m[1] + fmul(cy, imass_m[1]));
        end
      end
      CMD_READ: ;
      default: return;
    endcase
    for (int k = 0; k < 2; k++) begin
      r.which_body = k[0];
      r.out_pos_x = pos_x_m[k][31:0];
      r.out_pos_y = pos_y_m[k][31:0];
      r.out_vel_x = vel_x_m[k][31:0];
      r.out_vel_y = vel_y_m[k][31:0];
      r.out_spin = spin_m[k][31:0];
      r.out_acc_normal = accn_m[sl][30:0];
      r.out_acc_tangent = acct_m[sl][31:0];
      r.solve_status = st;
      r.last_item = k[0];
      body_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_bodies(in_ch.data);
        item_count++;
      end
      if ((!in_ch.valid || in_ch.ready) && pending_items.size() > 0 &&
          (quiet_mode || $urandom_range(99) >= 16)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items.pop_front();
      end else if (in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (body_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.data);
          error_count++;
        end else if (out_ch.data !== body_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, body_results[0], out_ch.data);
          error_count++;
          void'(body_results.pop_front());
        end else begin
          void'(body_results.pop_front());
        end
      end
      out_ch.ready <= !hold_off && (quiet_mode || $urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input longint val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: val[31:0]};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_NORMAL_X:    nx_r = $signed(val[17:0]);
      REG_NORMAL_Y:    ny_r = $signed(val[17:0]);
      REG_RESTITUTION: rest_r = val[16:0];
      REG_FRICTION:    mu_r = val[20:0];
      REG_DEPTH:       depth_r = val[30:0];
      REG_BIAS:        bias_r = val[16:0];
      REG_SLOP:        slop_r = val[30:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || body_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic cis_in_t make_item(input cmd_t c, input int spread);
    cis_in_t it;
    it = '0;
    it.command = c;
    it.body_select = $urandom_range(1);
    it.contact_slot = $urandom_range(1);
    if (spread == 0) begin
      it.x_coord = $urandom;
      it.y_coord = $urandom;
      it.load_vel_x = $urandom;
      it.load_vel_y = $urandom;
      it.load_spin = $urandom;
      it.load_inv_mass = $urandom;
      it.load_inv_inertia = $urandom;
    end else begin
      it.x_coord = $signed($urandom_range(8 << 16)) - (4 << 16);
      it.y_coord = $signed($urandom_range(8 << 16)) - (4 << 16);
      it.load_vel_x = $signed($urandom_range(20 << 16)) - (10 << 16);
      it.load_vel_y = $signed($urandom_range(20 << 16)) - (10 << 16);
      it.load_spin = $signed($urandom_range(8 << 16)) - (4 << 16);
      it.load_inv_mass = ($urandom_range(7) == 0) ? 31'd0 : 31'($urandom_range(2 << 16));
      it.load_inv_inertia = ($urandom_range(7) == 0) ? 31'd0 : 31'($urandom_range(2 << 16));
    end
    return it;
  endfunction

  task automatic random_phase(input int count);
    int pick;
    cis_in_t it;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) it = make_item(CMD_LOAD, 0);
      else if (pick < 30) it = make_item(CMD_LOAD, 1);
      else if (pick < 75) it = make_item(CMD_SOLVE, $urandom_range(9) != 0);
      else if (pick < 85) it = make_item(CMD_CORRECT, 1);
      else if (pick < 90) it = make_item(CMD_CLEAR, 1);
      else if (pick < 97) it = make_item(CMD_READ, 1);
      else it = make_item(cmd_t'(3'($urandom_range(7, 5))), 0);
      pending_items.push_back(it);
    end
  endtask

  task automatic random_config(input int extreme);
    write_reg(REG_NORMAL_X, extreme == 1 ? -65536 : extreme == 2 ? 65536 :
              longint'($urandom_range(131072)) - 65536);
    write_reg(REG_NORMAL_Y, extreme == 1 ? 65536 : extreme == 2 ? -65536 :
              longint'($urandom_range(131072)) - 65536);
    write_reg(REG_RESTITUTION, extreme == 1 ? 0 : extreme == 2 ? 65536 : $urandom_range(65536));
    write_reg(REG_FRICTION, extreme == 1 ? 0 : extreme == 2 ? 1048576 : $urandom_range(1048576));
    write_reg(REG_DEPTH, extreme == 2 ? 2147483647 : longint'($urandom) & 64'h7fffffff);
    write_reg(REG_BIAS, extreme == 1 ? 0 : extreme == 2 ? 65536 : $urandom_range(65536));
    write_reg(REG_SLOP, extreme == 1 ? 2147483647 : extreme == 2 ? 0 : $urandom_range(65536));
  endtask

  initial begin
    cis_in_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    error_count = 0;
    item_count = 0;
    result_count = 0;
    quiet_mode = 1'b0;
    hold_off = 1'b0;
    pos_x_m = '{0, 0}; pos_y_m = '{0, 0}; vel_x_m = '{0, 0}; vel_y_m = '{0, 0};
    spin_m = '{0, 0}; imass_m = '{0, 0}; iinert_m = '{0, 0};
    accn_m = '{0, 0}; acct_m = '{0, 0};
    nx_r = 0; ny_r = 65536; rest_r = 0; mu_r = 0; depth_r = 0; bias_r = 13107; slop_r = 655;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_items.push_back(make_item(CMD_READ, 1));
    pending_items.push_back(make_item(CMD_SOLVE, 1));
    pending_items.push_back(make_item(CMD_CORRECT, 1));
    wait_drained();
    write_reg(REG_FRICTION, 32768);
    write_reg(REG_DEPTH, 65536);
    write_reg(REG_RESTITUTION, 65536);

    it = '0;
    it.command = CMD_LOAD;
    it.load_vel_y = 2 << 16;
    it.load_inv_mass = 65536;
    it.load_inv_inertia = 65536;
    it.load_vel_x = 65536;
    pending_items.push_back(it);
    it.body_select = 1'b1;
    it.y_coord = 65536;
    it.load_vel_y = -(2 << 16);
    it.load_vel_x = 0;
    pending_items.push_back(it);
    it = '0;
    it.command = CMD_SOLVE;
    it.y_coord = 32768;
    pending_items.push_back(it);
    it.contact_slot = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(it);
    it = '0;
    it.command = CMD_CORRECT;
    pending_items.push_back(it);
    it.command = CMD_CLEAR;
    pending_items.push_back(it);
    it.command = CMD_READ;
    pending_items.push_back(it);
    it = '0;
    it.command = CMD_LOAD;
    it.body_select = 1'b0;
    it.x_coord = 32'sh7fffffff;
    it.y_coord = 32'sh80000000;
    it.load_vel_x = 32'sh80000000;
    it.load_vel_y = 32'sh7fffffff;
    it.load_spin = 32'sh7fffffff;
    it.load_inv_mass = 31'h7fffffff;
    it.load_inv_inertia = 31'h7fffffff;
    pending_items.push_back(it);
    it.command = CMD_SOLVE;
    pending_items.push_back(it);
    it.command = CMD_CORRECT;
    pending_items.push_back(it);
    it = '0;
    it.command = CMD_LOAD;
    pending_items.push_back(it);
    it.body_select = 1'b1;
    pending_items.push_back(it);
    it.command = CMD_SOLVE;
    it.y_coord = 65536;
    pending_items.push_back(it);
    it.command = CMD_CORRECT;
    pending_items.push_back(it);
    it.command = cmd_t'(3'd7);
    pending_items.push_back(it);
    it.command = CMD_READ;
    pending_items.push_back(it);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph < 3 ? ph : 0);
      if (ph == 4) begin
        quiet_mode = 1'b1;
        random_phase(200);
        wait_drained();
        quiet_mode = 1'b0;
      end else if (ph == 5) begin
        random_phase(200);
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
        wait_drained();
      end else begin
        random_phase(255);
        wait_drained();
      end
    end

    $display("Ran %0d items and checked %0d body results over loads, solves,", item_count,
             result_count);
    $display("corrections, clears, reads and ignored codes under eight register settings.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cis_pkg.sv
src/cis_chan_if.sv
src/cis_div.sv
src/contact_impulse_solver_2d_top.sv
test/contact_impulse_solver_2d_top_tb.sv
